// File: src/assert_macros.svh
// Assertion macros used by the top level of the seed-to-key generator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: src/skg_pkg.sv
// Shared types, codes, constants and functions for the seed-to-key generator.
package skg_pkg;

    localparam int CountW = 7;
    localparam logic [CountW-1:0] COUNT_BIAS = 7'h1F;
    localparam logic [CountW-1:0] ARITH_LAST = 7'd6;

    typedef logic [3:0] skg_op_t;

    localparam skg_op_t OP_IDLE    = 4'd0;
    localparam skg_op_t OP_SHX     = 4'd1;
    localparam skg_op_t OP_ADD_CHI = 4'd2;
    localparam skg_op_t OP_AMIX    = 4'd3;
    localparam skg_op_t OP_XOR_SHI = 4'd4;
    localparam skg_op_t OP_ADD_CLO = 4'd5;
    localparam skg_op_t OP_BMIX    = 4'd6;
    localparam skg_op_t OP_CMIX    = 4'd7;
    localparam skg_op_t OP_KHI     = 4'd8;

    localparam logic REG_ALG  = 1'b0;
    localparam logic REG_CODE = 1'b1;

    typedef struct packed {
        logic    load;
        skg_op_t op;
        logic    finish;
    } skg_ctl_t;

    function automatic logic [CountW-1:0] skg_loop_count(input logic [31:0] seed);
        logic [CountW-1:0] raw;
        raw = {seed[0], 1'b0, seed[9], seed[1], seed[11], seed[2], seed[5]};
        return raw + COUNT_BIAS;
    endfunction

    function automatic logic [3:0] skg_table_index(input logic [31:0] seed);
        return {seed[0], seed[1], seed[2], seed[9]};
    endfunction

    function automatic logic [31:0] skg_xor_word(input logic [3:0] idx);
        logic [31:0] w;
        case (idx)
            4'h0: w = 32'h14FA3579;
            4'h1: w = 32'h27CD3964;
            4'h2: w = 32'h1777FE32;
            4'h3: w = 32'h9931AF12;
            4'h4: w = 32'h75DB3A49;
            4'h5: w = 32'h19294CAA;
            4'h6: w = 32'hFF18CD76;
            4'h7: w = 32'h0788236D;
            4'h8: w = 32'h5A6F7CBB;
            4'h9: w = 32'h7A992254;
            4'hA: w = 32'hADFD5414;
            4'hB: w = 32'h343CFBCB;
            4'hC: w = 32'hC2F51639;
            4'hD: w = 32'h6A6D5813;
            4'hE: w = 32'h3729FF68;
            default: w = 32'h22A2C751;
        endcase
        return w;
    endfunction

endpackage

// File: src/skg_seq.sv
// Sequencer that steps the shared unit through either key algorithm.
module skg_seq
    import skg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] seed_word,
    input  logic        alg_sel,
    output logic        busy,
    output skg_ctl_t    ctl
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_TABLE = 2'd1;
    localparam logic [1:0] ST_ARITH = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [CountW-1:0] count_reg, count_next;
    logic              accept;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ctl.load   = accept;
        ctl.op     = OP_IDLE;
        ctl.finish = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (alg_sel)
                    begin
                        state_next = ST_ARITH;
                        count_next = '0;
                    end
                    else
                    begin
                        state_next = ST_TABLE;
                        count_next = skg_loop_count(seed_word);
                    end
                end
            end
            ST_TABLE:
            begin
                // Count holds the passes still to run, never zero here.
                ctl.op     = OP_SHX;
                count_next = count_reg - 1'b1;
                if (count_reg == 7'd1)
                begin
                    ctl.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_ARITH:
            begin
                case (count_reg)
                    7'd0:    ctl.op = OP_ADD_CHI;
                    7'd1:    ctl.op = OP_AMIX;
                    7'd2:    ctl.op = OP_XOR_SHI;
                    7'd3:    ctl.op = OP_ADD_CLO;
                    7'd4:    ctl.op = OP_BMIX;
                    7'd5:    ctl.op = OP_CMIX;
                    7'd6:    ctl.op = OP_KHI;
                    default: ctl.op = OP_IDLE;
                endcase
                count_next = count_reg + 1'b1;
                if (count_reg == ARITH_LAST)
                begin
                    ctl.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

endmodule

// File: src/skg_alu.sv
// Shared datapath: a 32-bit shift-xor step or one 16-bit mixing step per cycle.
module skg_alu
    import skg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  skg_ctl_t    ctl,
    input  logic [31:0] seed_word,
    input  logic [31:0] code,
    output logic        done,
    output logic [31:0] key_word
);

    logic [31:0] w_reg, w_next;
    logic [31:0] seed_reg;
    logic [3:0]  idx_reg;
    logic [15:0] klo_reg;
    logic [15:0] bm_reg;
    logic [31:0] key_reg;
    logic        done_reg;
    logic [15:0] t;
    logic [15:0] res16;

    assign t = w_reg[15:0];

    always_comb
    begin
        res16  = t;
        w_next = w_reg;
        case (ctl.op)
            OP_SHX:
            begin
                w_next = {w_reg[30:0], 1'b0} ^ (w_reg[31] ? skg_xor_word(idx_reg) : 32'h0);
            end
            OP_ADD_CHI: res16 = code[31:16] + seed_reg[15:0];
            OP_AMIX:    res16 = {14'h0, t[15:14]} + t + {t[13:0], 2'b00} - 16'd1;
            OP_XOR_SHI: res16 = t ^ seed_reg[31:16];
            OP_ADD_CLO: res16 = code[15:0] + t;
            OP_BMIX:    res16 = {15'h0, t[15]} + t + {t[14:0], 1'b0} - 16'd1;
            OP_CMIX:    res16 = {t[11:0], 4'h0} + {12'h0, t[15:12]};
            OP_KHI:     res16 = seed_reg[15:0] ^ t ^ bm_reg;
            default:    res16 = t;
        endcase
        if (ctl.op == OP_KHI)
        begin
            w_next = {res16, klo_reg};
        end
        else if (ctl.op != OP_SHX && ctl.op != OP_IDLE)
        begin
            w_next = {w_reg[31:16], res16};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            w_reg    <= seed_word;
            seed_reg <= seed_word;
            idx_reg  <= skg_table_index(seed_word);
        end
        else
        begin
            w_reg <= w_next;
        end
        if (ctl.op == OP_XOR_SHI)
        begin
            klo_reg <= res16;
        end
        if (ctl.op == OP_BMIX)
        begin
            bm_reg <= res16;
        end
        if (ctl.finish)
        begin
            key_reg <= w_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctl.finish;
        end
    end

    assign done     = done_reg;
    assign key_word = key_reg;

endmodule

// File: src/seed_key_generator_core.sv
// Top level of the seed-to-key generator: configuration registers and units.
//
// Usage: drive seed_word and raise start while busy is low; the request is
// taken at that clock edge and busy rises for the duration of the work.
// The key appears on key_word with done high for exactly one cycle.
// The table algorithm (algorithm_select = 0) runs one shift-xor pass per
// cycle; the pass count taken from the seed is 31 to 126, and done is
// registered (done_reg) from the finish flag of the last pass.
// The arithmetic algorithm (algorithm_select = 1) runs seven 16-bit steps in
// the shared unit, and done is registered in the same way from the last step.
// busy falls in the same cycle that done is shown, so a new request may be
// taken while the previous key is on the outputs.
// Configuration: cfg_index 0 writes algorithm_select (bit 0 of cfg_data),
// index 1 writes scramble_code; cfg_ready is always high. Write only while
// idle. Reset clears both registers and returns the block to idle.
// The receiver cannot stall: done is high for one cycle only, and key_word holds the key until the next one.
module seed_key_generator_core
    import skg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] seed_word,
    output logic        done,
    output logic [31:0] key_word,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

`include "assert_macros.svh"

    logic        alg_reg, alg_next;
    logic [31:0] code_reg, code_next;
    skg_ctl_t    ctl;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        alg_next  = alg_reg;
        code_next = code_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_ALG:  alg_next  = cfg_data[0];
                REG_CODE: code_next = cfg_data;
                default:  alg_next  = alg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alg_reg  <= 1'b0;
            code_reg <= 32'h0;
        end
        else
        begin
            alg_reg  <= alg_next;
            code_reg <= code_next;
        end
    end

    skg_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .seed_word (seed_word),
        .alg_sel   (alg_reg),
        .busy      (busy),
        .ctl       (ctl)
    );

    skg_alu u_alu (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .seed_word (seed_word),
        .code      (code_reg),
        .done      (done),
        .key_word  (key_word)
    );

    // A taken request always starts work, and a key only ends work.
    `ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    `ASSERT_SAME(a_done_after_busy, done, $past(busy))
    `ASSERT_SAME(a_done_idle, done, !busy)
    `ASSERT_SAME(a_finish_no_load, ctl.finish, !ctl.load)

endmodule

// File: verif/skg_checker.sv
// Checker for the seed-to-key generator: predicts every key and compares it with the block.
module skg_checker
    import skg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [31:0] seed_word,
    input  logic        done,
    input  logic [31:0] key_word,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    output int          mismatch_count,
    output int          keys_pending
);

    // Feedback words of the table algorithm, word 15 first.
    localparam logic [15:0][31:0] MIX_WORDS = {
        32'h22A2C751, 32'h3729FF68, 32'h6A6D5813, 32'hC2F51639,
        32'h343CFBCB, 32'hADFD5414, 32'h7A992254, 32'h5A6F7CBB,
        32'h0788236D, 32'hFF18CD76, 32'h19294CAA, 32'h75DB3A49,
        32'h9931AF12, 32'h1777FE32, 32'h27CD3964, 32'h14FA3579
    };

    logic        alg_shadow;
    logic [31:0] code_shadow;
    logic [31:0] keys_due [$];
    logic [31:0] oldest_key;
    int          fail_tally;

    function automatic logic [31:0] table_walk_key(input logic [31:0] seed);
        logic [6:0]  passes;
        logic [3:0]  pick;
        logic [31:0] w;
        logic        top;
        passes = 7'd31 + {seed[0], 1'b0, seed[9], seed[1], seed[11], seed[2], seed[5]};
        pick   = {seed[0], seed[1], seed[2], seed[9]};
        w      = seed;
        for (int i = 0; i < passes; i++)
        begin
            top = w[31];
            w   = {w[30:0], 1'b0};
            if (top)
                w = w ^ MIX_WORDS[pick];
        end
        return w;
    endfunction

    function automatic logic [31:0] scramble_mix_key(input logic [31:0] seed,
                                                     input logic [31:0] code);
        logic [15:0] a, a_mix, k_lo, b, b_mix, c_mix, k_hi;
        logic [31:0] a4, b2, b16, sum;
        a     = code[31:16] + seed[15:0];
        a4    = {14'b0, a, 2'b00};
        sum   = (a4 >> 16) + {16'b0, a} + a4 - 32'd1;
        a_mix = sum[15:0];
        k_lo  = a_mix ^ seed[31:16];
        b     = code[15:0] + k_lo;
        b2    = {15'b0, b, 1'b0};
        sum   = (b2 >> 16) + {16'b0, b} + b2 - 32'd1;
        b_mix = sum[15:0];
        b16   = {12'b0, b_mix, 4'b0};
        sum   = b16 + (b16 >> 16);
        c_mix = sum[15:0];
        k_hi  = seed[15:0] ^ c_mix ^ b_mix;
        return {k_hi, k_lo};
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("mismatch at %0t: %s, expected %h, got %h", $time, what, want, got);
        fail_tally = fail_tally + 1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alg_shadow  = 1'b0;
            code_shadow = '0;
            keys_due.delete();
            fail_tally  = 0;
        end
        else
        begin
            // The key leaving at this edge belongs to an earlier request, so retire first.
            if (done)
            begin
                if (keys_due.size() == 0)
                    report_mismatch("key_word with no request waiting", '0, key_word);
                else
                begin
                    oldest_key = keys_due.pop_front();
                    if (key_word !== oldest_key)
                        report_mismatch("key_word", oldest_key, key_word);
                end
            end
            if (start && !busy)
            begin
                if (alg_shadow)
                    keys_due.push_back(scramble_mix_key(seed_word, code_shadow));
                else
                    keys_due.push_back(table_walk_key(seed_word));
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_ALG)
                    alg_shadow = cfg_data[0];
                else if (cfg_index == REG_CODE)
                    code_shadow = cfg_data;
            end
        end
        mismatch_count <= fail_tally;
        keys_pending   <= keys_due.size();
    end

endmodule

// File: verif/tb.sv
// Testbench top for the seed-to-key generator: stimulus, watchdog and final verdict.
module tb;
    import skg_pkg::*;

    localparam int StallLimit  = 2000;
    localparam int DrainCycles = 140;
    localparam int RandomPhases = 8;
    localparam int PhaseItems  = 238;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [31:0] seed_word;
    logic        done;
    logic [31:0] key_word;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [31:0] cfg_data;

    int mismatch_count;
    int keys_pending;
    int stall_cycles = 0;
    bit quiet_sender = 1'b0;

    seed_key_generator_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .seed_word (seed_word),
        .done      (done),
        .key_word  (key_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    skg_checker key_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .seed_word      (seed_word),
        .done           (done),
        .key_word       (key_word),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .keys_pending   (keys_pending)
    );

    initial clk = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Ends the run when nothing at all is taken for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done || (cfg_valid && cfg_ready))
                stall_cycles <= 0;
            else if (stall_cycles >= StallLimit)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    // Long gaps land anywhere in the block's work, from right after a request to well past it.
    function automatic int pick_gap();
        if (!quiet_sender && $urandom_range(99) < 21)
            return $urandom_range(140, 1);
        return 0;
    endfunction

    task automatic send_seed(input logic [31:0] seed);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start     <= 1'b1;
        seed_word <= seed;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (keys_pending != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] value);
        int gap;
        gap = pick_gap();
        repeat (gap) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Only bit 0 of the data counts for the algorithm register; the rest is noise.
    task automatic set_mode(input logic alg, input logic [31:0] code);
        logic [31:0] noise;
        noise = $urandom;
        if ($urandom_range(1))
        begin
            write_reg(REG_ALG, {noise[31:1], alg});
            write_reg(REG_CODE, code);
        end
        else
        begin
            write_reg(REG_CODE, code);
            write_reg(REG_ALG, {noise[31:1], alg});
        end
    endtask

    function automatic logic [31:0] random_seed();
        case ($urandom_range(9))
            0: return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0000;
            1: return $urandom | 32'h0000_0A27;
            2: return $urandom & ~32'h0000_0A27;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        logic [31:0] seed;
        logic        alg;
        logic [31:0] code;

        rst_n     = 1'b0;
        start     = 1'b0;
        seed_word = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_ALG;
        cfg_data  = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Table algorithm out of reset: shortest and longest loops, then every table word.
        send_seed(32'h0000_0000);
        send_seed(32'hFFFF_FFFF);
        wait_idle();
        // The scramble code must not affect the table algorithm.
        write_reg(REG_CODE, 32'hA5C3_5A3C);
        for (int k = 0; k < 16; k++)
        begin
            seed    = $urandom;
            seed[9] = k[0];
            seed[2] = k[1];
            seed[1] = k[2];
            seed[0] = k[3];
            send_seed(seed);
        end
        wait_idle();

        // Arithmetic algorithm: zero and all-ones codes drive the 16-bit wraps.
        set_mode(1'b1, 32'h0000_0000);
        send_seed(32'h0000_0000);
        send_seed(32'hFFFF_FFFF);
        send_seed(32'h0000_FFFF);
        wait_idle();
        set_mode(1'b1, 32'hFFFF_FFFF);
        send_seed(32'h0000_0000);
        send_seed(32'hFFFF_FFFF);
        send_seed(32'h0001_0001);
        wait_idle();

        for (int phase = 0; phase < RandomPhases; phase++)
        begin
            case (phase)
                0:
                begin
                    alg  = 1'b0;
                    code = $urandom;
                end
                1:
                begin
                    alg  = 1'b1;
                    code = 32'h0000_0000;
                end
                2:
                begin
                    alg  = 1'b1;
                    code = 32'hFFFF_FFFF;
                end
                default:
                begin
                    alg  = $urandom_range(1);
                    code = $urandom;
                end
            endcase
            quiet_sender = (phase == 3);
            set_mode(alg, code);
            for (int n = 0; n < PhaseItems; n++)
                send_seed(random_seed());
            wait_idle();
        end

        repeat (DrainCycles) @(posedge clk);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
